/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rasd_pkg.sv */
`default_nettype none

package rasd_pkg;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_ABORT  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ALIGNED  = 2'd1,
        ST_FAILED   = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_SETTLED_THRESHOLD = 2'd0,
        CFG_SETTLED_COUNT     = 2'd1,
        CFG_MAX_SAMPLES       = 2'd2,
        CFG_TIMEOUT_TICKS     = 2'd3
    } cfg_idx_t;

    localparam int unsigned FIELD_POS_W = 16;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned RUN_W       = 10;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned TDATA_W     = 24;

    localparam logic [15:0]      RST_SETTLED_THRESHOLD = 16'd64;
    localparam logic [RUN_W-1:0] RST_SETTLED_COUNT     = 10'd10;
    localparam logic [15:0]      RST_MAX_SAMPLES       = 16'd10000;
    localparam logic [15:0]      RST_TIMEOUT_TICKS     = 16'd1000;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [RUN_W-1:0] RUN_MAX = '1;

endpackage

`default_nettype wire

/* rtl/rotor_alignment_settle_detector.sv */
// Channel  | Ports            | tdata (low bit up)                     | tuser
// ---------+------------------+----------------------------------------+---------------
// input    | s_tvalid/s_tready | position[15:0], over_current, zeros   | req_type[1:0]
// result   | m_tvalid/m_tready | aligned_position[15:0], busy_res, 0s  | status[1:0]
// config   | cfg_wr_en         | cfg_addr selects, cfg_wdata[15:0]      | -
//
// Each transfer yields exactly one result through an input register and a
// result register; one item is taken every cycle unless a result stall fills both.
// The run state is updated in the same cycle that loads the result register.
// A stall on the result side holds the result register; s_tready drops only
// once the input register is full as well, and then both registers hold.
// aresetn is synchronous and active low; it clears the run and loads the
// register reset values.
`default_nettype none

module rotor_alignment_settle_detector #(
    parameter int unsigned POS_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // position[15:0], over_current[16], zero fill
    input  wire logic [rasd_pkg::TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // aligned_position[15:0], busy_res[16], zero fill
    output logic [rasd_pkg::TDATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [1:0]                         m_tuser,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [rasd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rasd_pkg::*;

    `include "assert_macros.svh"

    localparam int unsigned CMP_W = (POS_BITS > FIELD_POS_W) ? POS_BITS : FIELD_POS_W;

    logic [15:0]         thr_reg;
    logic [RUN_W-1:0]    scnt_reg;
    logic [15:0]         maxs_reg;
    logic [15:0]         tmo_reg;

    logic                in_valid_reg;
    req_t                in_req_reg;
    logic [POS_BITS-1:0] in_pos_reg;
    logic                in_over_reg;

    logic                running_reg, running_next;
    logic [CNT_W-1:0]    sample_count_reg, sample_count_next;
    logic [RUN_W-1:0]    settled_run_reg, settled_run_next;
    logic [POS_BITS-1:0] last_position_reg, last_position_next;
    logic [CNT_W-1:0]    tick_count_reg, tick_count_next;

    logic                out_valid_reg;
    status_t             out_status_reg, out_status_next;
    logic [15:0]         out_aligned_reg, out_aligned_next;
    logic                out_busy_reg;

    logic                out_load;
    logic                proc;
    logic [CNT_W-1:0]    sample_inc;
    logic [CNT_W-1:0]    tick_inc;
    logic [RUN_W-1:0]    run_inc;
    logic [POS_BITS-1:0] diff;
    logic                settled;

    assign out_load = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= RST_SETTLED_THRESHOLD;
            scnt_reg <= RST_SETTLED_COUNT;
            maxs_reg <= RST_MAX_SAMPLES;
            tmo_reg  <= RST_TIMEOUT_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SETTLED_THRESHOLD: thr_reg  <= cfg_wdata;
                CFG_SETTLED_COUNT:     scnt_reg <= cfg_wdata[RUN_W-1:0];
                CFG_MAX_SAMPLES:       maxs_reg <= cfg_wdata;
                CFG_TIMEOUT_TICKS:     tmo_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= req_t'(s_tuser);
            in_pos_reg  <= POS_BITS'(s_tdata[FIELD_POS_W-1:0]);
            in_over_reg <= s_tdata[FIELD_POS_W];
        end
    end

    assign sample_inc = (sample_count_reg == CNT_MAX) ? sample_count_reg
                                                      : sample_count_reg + 1'b1;
    assign tick_inc   = (tick_count_reg == CNT_MAX) ? tick_count_reg
                                                    : tick_count_reg + 1'b1;
    assign run_inc    = (settled_run_reg == RUN_MAX) ? settled_run_reg
                                                     : settled_run_reg + 1'b1;
    assign diff       = (in_pos_reg >= last_position_reg) ? in_pos_reg - last_position_reg
                                                          : last_position_reg - in_pos_reg;
    assign settled    = CMP_W'(diff) < CMP_W'(thr_reg);

    always_comb begin
        running_next       = running_reg;
        sample_count_next  = sample_count_reg;
        settled_run_next   = settled_run_reg;
        last_position_next = last_position_reg;
        tick_count_next    = tick_count_reg;
        out_status_next    = ST_NONE;
        out_aligned_next   = '0;
        unique case (in_req_reg)
            REQ_START: begin
                if (running_reg) begin
                    out_status_next = ST_REJECTED;
                end else begin
                    running_next       = 1'b1;
                    sample_count_next  = '0;
                    settled_run_next   = '0;
                    tick_count_next    = '0;
                    last_position_next = in_pos_reg;
                end
            end
            REQ_SAMPLE: begin
                if (running_reg) begin
                    if (in_over_reg) begin
                        running_next    = 1'b0;
                        out_status_next = ST_FAILED;
                    end else begin
                        sample_count_next = sample_inc;
                        if (sample_inc >= maxs_reg) begin
                            running_next    = 1'b0;
                            out_status_next = ST_FAILED;
                        end else begin
                            last_position_next = in_pos_reg;
                            if (settled) begin
                                settled_run_next = run_inc;
                                if (run_inc >= scnt_reg) begin
                                    running_next     = 1'b0;
                                    out_status_next  = ST_ALIGNED;
                                    out_aligned_next = 16'(in_pos_reg);
                                end
                            end else begin
                                settled_run_next = '0;
                            end
                        end
                    end
                end
            end
            REQ_TICK: begin
                if (running_reg) begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= tmo_reg) begin
                        running_next    = 1'b0;
                        out_status_next = ST_FAILED;
                    end
                end
            end
            REQ_ABORT: begin
                running_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg       <= 1'b0;
            sample_count_reg  <= '0;
            settled_run_reg   <= '0;
            last_position_reg <= '0;
            tick_count_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
            if (proc) begin
                running_reg       <= running_next;
                sample_count_reg  <= sample_count_next;
                settled_run_reg   <= settled_run_next;
                last_position_reg <= last_position_next;
                tick_count_reg    <= tick_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_status_reg  <= out_status_next;
            out_aligned_reg <= out_aligned_next;
            out_busy_reg    <= running_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(TDATA_W - FIELD_POS_W - 1){1'b0}}, out_busy_reg, out_aligned_reg};

    `ASSERT_SAME(a_aligned_ends_run, aclk, aresetn,
        m_tvalid && m_tuser == ST_ALIGNED, !m_tdata[FIELD_POS_W],
        "An aligned result reports the run as still active.")
    `ASSERT_NEXT(a_state_holds_when_idle, aclk, aresetn,
        !proc, $stable(running_reg) && $stable(sample_count_reg),
        "Run state changed without an item being processed.")
    `ASSERT_NEXT(a_start_opens_run, aclk, aresetn,
        proc && in_req_reg == REQ_START && !running_reg,
        running_reg && sample_count_reg == '0 && settled_run_reg == '0,
        "An accepted start did not open a fresh run.")

endmodule

`default_nettype wire
